// ===== hdl/aarm_pkg.sv =====
// Package for the axis-angle rotation matrix block: fixed-point constants,
// the CORDIC arctangent table and shared helper functions. No dependencies.
package aarm_pkg;

  localparam int unsigned CordicN = 24;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps = 57;

  localparam logic signed [27:0] HalfPi  = 28'sd26353589;
  localparam logic signed [27:0] FullPi  = 28'sd52707179;
  localparam logic signed [27:0] CordicK = 28'sd10188014;
  localparam logic signed [27:0] Q24One  = 28'sd16777216;

  // Arctangent of 2^-i in Q24 radians.
  function automatic logic signed [27:0] atan_q24(input logic [4:0] idx);
    logic signed [27:0] r;
    unique case (idx)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      default: r = 28'sd65536 >>> (idx - 5'd8);
    endcase
    return r;
  endfunction

  // Product of two Q24 values, floored back to Q24.
  function automatic logic signed [27:0] mul24(input logic signed [27:0] a,
                                               input logic signed [27:0] b);
    logic signed [55:0] p;
    p = a * b;
    return p[51:24];
  endfunction

  // Round a Q24 value half up to Q14 and saturate to plus or minus one.
  function automatic logic signed [15:0] to_q14(input logic signed [29:0] v);
    logic signed [29:0] r;
    r = (v + 30'sd512) >>> 10;
    if (r > 30'sd16384) r = 30'sd16384;
    else if (r < -30'sd16384) r = -30'sd16384;
    return r[15:0];
  endfunction

endpackage

// ===== hdl/aarm_cordic.sv =====
// Pipelined CORDIC: reduced angle in, cosine and sine in Q24 out, one
// rotation step per stage. Depends on aarm_pkg.
module aarm_cordic (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [27:0]  theta_i,
  input  logic                flip_i,
  output logic signed [27:0]  cos_o,
  output logic signed [27:0]  sin_o
);

  logic signed [27:0] x_q [aarm_pkg::CordicN+1];
  logic signed [27:0] y_q [aarm_pkg::CordicN+1];
  logic signed [27:0] z_q [aarm_pkg::CordicN+1];
  logic               f_q [aarm_pkg::CordicN+1];

  // Stage zero takes the reduced angle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= aarm_pkg::CordicK;
      y_q[0] <= '0;
      z_q[0] <= theta_i;
      f_q[0] <= flip_i;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < aarm_pkg::CordicN; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - aarm_pkg::atan_q24(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + aarm_pkg::atan_q24(5'(i));
        end
        f_q[i+1] <= f_q[i];
      end
    end
  end

  assign cos_o = f_q[aarm_pkg::CordicN] ? -x_q[aarm_pkg::CordicN] : x_q[aarm_pkg::CordicN];
  assign sin_o = f_q[aarm_pkg::CordicN] ? -y_q[aarm_pkg::CordicN] : y_q[aarm_pkg::CordicN];

endmodule

// ===== hdl/aarm_norm.sv =====
// Pipelined axis normaliser: integer square root of the squared length,
// then restoring division per component. Depends on aarm_pkg.
module aarm_norm (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] ax_i,
  input  logic signed [15:0] ay_i,
  input  logic signed [15:0] az_i,
  output logic signed [27:0] ux_o,
  output logic signed [27:0] uy_o,
  output logic signed [27:0] uz_o
);

  // Length in Q16 is below 2^32; the unit component stays below 2^26.
  localparam int unsigned QBits = 26;

  logic [31:0] sv_q  [aarm_pkg::SqrtSteps+1];
  logic [32:0] rem_q [aarm_pkg::SqrtSteps+1];
  logic [31:0] rt_q  [aarm_pkg::SqrtSteps+1];
  logic [15:0] sm_q  [aarm_pkg::SqrtSteps+1][3];
  logic        ss_q  [aarm_pkg::SqrtSteps+1][3];

  // Squared length and component magnitudes; the sum is at most 3*2^30.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sv_q[0]  <= 32'(ax_i * ax_i) + 32'(ay_i * ay_i) + 32'(az_i * az_i);
      rem_q[0] <= '0;
      rt_q[0]  <= '0;
      sm_q[0][0] <= ax_i[15] ? 16'(-ax_i) : ax_i;
      sm_q[0][1] <= ay_i[15] ? 16'(-ay_i) : ay_i;
      sm_q[0][2] <= az_i[15] ? 16'(-az_i) : az_i;
      ss_q[0][0] <= ax_i[15];
      ss_q[0][1] <= ay_i[15];
      ss_q[0][2] <= az_i[15];
    end
  end

  // Square root, one result bit per stage. Radicand is sum * 2^32.
  for (genvar i = 0; i < aarm_pkg::SqrtSteps; i++) begin : g_sqrt
    logic [63:0] rad;
    logic [34:0] trial;
    logic [34:0] rn;
    always_comb begin
      rad   = {sv_q[i], 32'd0};
      rn    = {rem_q[i], rad[63-2*i -: 2]};
      trial = {1'b0, rt_q[i], 2'b01};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rn >= trial) begin
          rem_q[i+1] <= 33'(rn - trial);
          rt_q[i+1]  <= {rt_q[i][30:0], 1'b1};
        end else begin
          rem_q[i+1] <= rn[32:0];
          rt_q[i+1]  <= {rt_q[i][30:0], 1'b0};
        end
        sv_q[i+1] <= sv_q[i];
        sm_q[i+1] <= sm_q[i];
        ss_q[i+1] <= ss_q[i];
      end
    end
  end

  // Rounded quotient (mag*2^40 + len/2) / len, one bit per stage.
  logic [31:0]      ln_q [aarm_pkg::DivSteps+1];
  logic [56:0]      nm_q [aarm_pkg::DivSteps+1][3];
  logic [31:0]      dr_q [aarm_pkg::DivSteps+1][3];
  logic [QBits-1:0] dq_q [aarm_pkg::DivSteps+1][3];
  logic             ds_q [aarm_pkg::DivSteps+1][3];

  // Dividend set-up with half the length added for rounding.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ln_q[0] <= rt_q[aarm_pkg::SqrtSteps];
      for (int k = 0; k < 3; k++) begin
        nm_q[0][k] <= {1'b0, sm_q[aarm_pkg::SqrtSteps][k], 40'd0}
                      + 57'(rt_q[aarm_pkg::SqrtSteps] >> 1);
        dr_q[0][k] <= '0;
        dq_q[0][k] <= '0;
        ds_q[0][k] <= ss_q[aarm_pkg::SqrtSteps][k];
      end
    end
  end

  for (genvar i = 0; i < aarm_pkg::DivSteps; i++) begin : g_div
    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [32:0] t;
      always_comb t = {dr_q[i][k], nm_q[i][k][aarm_pkg::DivSteps-1-i]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (t >= {1'b0, ln_q[i]}) begin
            dr_q[i+1][k] <= 32'(t - {1'b0, ln_q[i]});
            dq_q[i+1][k] <= {dq_q[i][k][QBits-2:0], 1'b1};
          end else begin
            dr_q[i+1][k] <= t[31:0];
            dq_q[i+1][k] <= {dq_q[i][k][QBits-2:0], 1'b0};
          end
          nm_q[i+1][k] <= nm_q[i][k];
          ds_q[i+1][k] <= ds_q[i][k];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) ln_q[i+1] <= ln_q[i];
    end
  end

  function automatic logic signed [27:0] apply_sign(input logic [QBits-1:0] q,
                                                    input logic s);
    logic signed [27:0] v;
    v = 28'(q);
    return s ? -v : v;
  endfunction

  assign ux_o = apply_sign(dq_q[aarm_pkg::DivSteps][0], ds_q[aarm_pkg::DivSteps][0]);
  assign uy_o = apply_sign(dq_q[aarm_pkg::DivSteps][1], ds_q[aarm_pkg::DivSteps][1]);
  assign uz_o = apply_sign(dq_q[aarm_pkg::DivSteps][2], ds_q[aarm_pkg::DivSteps][2]);

endmodule

// ===== hdl/axis_angle_rotation_matrix.sv =====
// Top level of the axis-angle rotation matrix block. Depends on aarm_pkg,
// aarm_cordic and aarm_norm.
//
// Accepts one word per cycle (busy is always low) and delivers each matrix
// with done_o high for one cycle; the receiver cannot stall. The delay is
// set by the axis normaliser: an input register, the 32-step square root,
// a set-up register and the 57-step restoring divider, followed by three
// stages of products and sums. The CORDIC runs beside the normaliser and is
// delayed to meet it.
module axis_angle_rotation_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] angle_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  output logic               done_o,
  output logic signed [15:0] m00_o,
  output logic signed [15:0] m01_o,
  output logic signed [15:0] m02_o,
  output logic signed [15:0] m10_o,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m20_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m22_o,
  output logic               axis_zero_o
);

  // Normaliser depth: input, square root, set-up, divider. CORDIC: 1 + 24.
  localparam int unsigned NormLat = 1 + aarm_pkg::SqrtSteps + 1 + aarm_pkg::DivSteps;
  localparam int unsigned CordLat = 1 + aarm_pkg::CordicN;
  localparam int unsigned Lat     = NormLat + 3;

  localparam logic signed [29:0] HalfPiW = 30'(aarm_pkg::HalfPi);
  localparam logic signed [29:0] FullPiW = 30'(aarm_pkg::FullPi);

  assign busy = 1'b0;
  logic en;
  assign en = 1'b1;

  // Angle reduction into [-pi/2, pi/2]; |theta| <= 8*2^24 needs up to three
  // steps of pi, picked by comparing against fixed thresholds.
  logic signed [29:0] th0, th3;
  logic               fl3;
  always_comb begin
    th0 = 30'(angle_i) <<< 12;
    priority if (th0 > HalfPiW + 30'sd2 * FullPiW) begin
      th3 = th0 - 30'sd3 * FullPiW; fl3 = 1'b1;
    end else if (th0 > HalfPiW + FullPiW) begin
      th3 = th0 - 30'sd2 * FullPiW; fl3 = 1'b0;
    end else if (th0 > HalfPiW) begin
      th3 = th0 - FullPiW; fl3 = 1'b1;
    end else if (th0 < -HalfPiW - 30'sd2 * FullPiW) begin
      th3 = th0 + 30'sd3 * FullPiW; fl3 = 1'b1;
    end else if (th0 < -HalfPiW - FullPiW) begin
      th3 = th0 + 30'sd2 * FullPiW; fl3 = 1'b0;
    end else if (th0 < -HalfPiW) begin
      th3 = th0 + FullPiW; fl3 = 1'b1;
    end else begin
      th3 = th0; fl3 = 1'b0;
    end
  end

  logic signed [27:0] th_q;
  logic               fl_q;
  always_ff @(posedge clk_i) begin
    th_q <= th3[27:0];
    fl_q <= fl3;
  end

  logic signed [27:0] cos_w, sin_w;
  aarm_cordic u_cordic (
    .clk_i, .en_i(en), .theta_i(th_q), .flip_i(fl_q), .cos_o(cos_w), .sin_o(sin_w)
  );

  logic signed [27:0] ux, uy, uz;
  aarm_norm u_norm (
    .clk_i, .en_i(en), .ax_i(axis_x_i), .ay_i(axis_y_i), .az_i(axis_z_i),
    .ux_o(ux), .uy_o(uy), .uz_o(uz)
  );

  // Delay the sine and cosine to meet the unit vector.
  localparam int unsigned CsDly = NormLat - CordLat - 1;
  logic signed [27:0] cd_q [CsDly];
  logic signed [27:0] sd_q [CsDly];
  always_ff @(posedge clk_i) begin
    cd_q[0] <= cos_w;
    sd_q[0] <= sin_w;
    for (int k = 1; k < CsDly; k++) begin
      cd_q[k] <= cd_q[k-1];
      sd_q[k] <= sd_q[k-1];
    end
  end

  // Valid and zero-axis flags travel along the pipe.
  logic [Lat-1:0] vld_q, zro_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end
  always_ff @(posedge clk_i) begin
    zro_q <= {zro_q[Lat-2:0], (axis_x_i == 0) && (axis_y_i == 0) && (axis_z_i == 0)};
  end

  // Stage A: (1-c)*u and s*u.
  logic signed [27:0] c_a, oux_a, ouy_a, ouz_a, sux_a, suy_a, suz_a;
  logic signed [27:0] ux_a, uy_a, uz_a, oc;
  assign oc = aarm_pkg::Q24One - cd_q[CsDly-1];
  always_ff @(posedge clk_i) begin
    c_a <= cd_q[CsDly-1];
    ux_a <= ux; uy_a <= uy; uz_a <= uz;
    oux_a <= aarm_pkg::mul24(oc, ux);
    ouy_a <= aarm_pkg::mul24(oc, uy);
    ouz_a <= aarm_pkg::mul24(oc, uz);
    sux_a <= aarm_pkg::mul24(ux, sd_q[CsDly-1]);
    suy_a <= aarm_pkg::mul24(uy, sd_q[CsDly-1]);
    suz_a <= aarm_pkg::mul24(uz, sd_q[CsDly-1]);
  end

  // Stage B: outer-product terms.
  logic signed [27:0] c_b, sux_b, suy_b, suz_b;
  logic signed [27:0] oxx_b, oyy_b, ozz_b, oxy_b, oyz_b, ozx_b;
  always_ff @(posedge clk_i) begin
    c_b <= c_a;
    sux_b <= sux_a; suy_b <= suy_a; suz_b <= suz_a;
    oxx_b <= aarm_pkg::mul24(oux_a, ux_a);
    oyy_b <= aarm_pkg::mul24(ouy_a, uy_a);
    ozz_b <= aarm_pkg::mul24(ouz_a, uz_a);
    oxy_b <= aarm_pkg::mul24(oux_a, uy_a);
    oyz_b <= aarm_pkg::mul24(ouy_a, uz_a);
    ozx_b <= aarm_pkg::mul24(ouz_a, ux_a);
  end

  // Stage C: sums, rounding and saturation, zeroed for a zero axis.
  logic signed [15:0] m_q [9];
  logic zf;
  assign zf = zro_q[Lat-2];
  function automatic logic signed [15:0] fin(input logic signed [27:0] a,
                                             input logic signed [27:0] b,
                                             input logic neg, input logic z);
    logic signed [29:0] v;
    v = neg ? 30'(a) - 30'(b) : 30'(a) + 30'(b);
    return z ? 16'sd0 : aarm_pkg::to_q14(v);
  endfunction
  always_ff @(posedge clk_i) begin
    m_q[0] <= fin(oxx_b, c_b, 1'b0, zf);
    m_q[1] <= fin(oxy_b, suz_b, 1'b1, zf);
    m_q[2] <= fin(ozx_b, suy_b, 1'b0, zf);
    m_q[3] <= fin(oxy_b, suz_b, 1'b0, zf);
    m_q[4] <= fin(oyy_b, c_b, 1'b0, zf);
    m_q[5] <= fin(oyz_b, sux_b, 1'b1, zf);
    m_q[6] <= fin(ozx_b, suy_b, 1'b1, zf);
    m_q[7] <= fin(oyz_b, sux_b, 1'b0, zf);
    m_q[8] <= fin(ozz_b, c_b, 1'b0, zf);
  end

  assign done_o = vld_q[Lat-1];
  assign axis_zero_o = zro_q[Lat-1];
  assign m00_o = m_q[0]; assign m01_o = m_q[1]; assign m02_o = m_q[2];
  assign m10_o = m_q[3]; assign m11_o = m_q[4]; assign m12_o = m_q[5];
  assign m20_o = m_q[6]; assign m21_o = m_q[7]; assign m22_o = m_q[8];

  // A zero axis always yields a zero matrix; m00, m11, m22 and m01 are checked.
  a_zero_mat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && axis_zero_o |-> m00_o == 0 && m11_o == 0 && m22_o == 0 && m01_o == 0)
    else $error("zero axis gave nonzero matrix");

  // The pipe never holds the sender off.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  // Diagonal entries stay in range; m00 is checked.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> m00_o <= 16'sd16384 && m00_o >= -16'sd16384)
    else $error("entry out of range");

endmodule
